>>> design/relation_property_closure_assert.svh
// assertion macros for the relation property and closure block
`ifndef RELATION_PROPERTY_CLOSURE_ASSERT_SVH
`define RELATION_PROPERTY_CLOSURE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rpc_pkg.sv
// shared types and constants of the relation property and closure block
`default_nettype none

package rpc_pkg;

   localparam int ROW_W = 16;

   localparam logic [1:0] KIND_REFL  = 2'd0;
   localparam logic [1:0] KIND_SYM   = 2'd1;
   localparam logic [1:0] KIND_TRANS = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WORK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       shift;
      logic       warsh;
      logic [3:0] pivot_bit;
   } cell_ctrl_type;

   typedef struct packed {
      logic refl;
      logic irrefl;
      logic sym;
      logic anti;
      logic trans;
   } flags_type;

   // ones in the low n bits, n from 1 to 16
   function automatic logic [ROW_W-1:0] row_mask(input logic [4:0] n);
      logic [ROW_W:0] ones;
      ones = ({{ROW_W{1'b0}}, 1'b1} << n) - {{ROW_W{1'b0}}, 1'b1};
      return ones[ROW_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> design/rpc_cell.sv
// one cell of the row chain: holds an original row and a working closure row
`default_nettype none

module rpc_cell
   import rpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              load_en,
   input  wire logic [ROW_W-1:0]  load_row,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [ROW_W-1:0]  pivot_row,
   input  wire logic [ROW_W-1:0]  nbr_row,
   output logic [ROW_W-1:0]       orig_row,
   output logic [ROW_W-1:0]       clos_row,
   output logic [ROW_W-1:0]       upd_row
);

   logic [ROW_W-1:0] orig_ff, orig_in;
   logic [ROW_W-1:0] clos_ff, clos_in;

   // warshall step: or in the pivot row when this row reaches the pivot; next rows: load, shift or hold
   always_comb begin
      upd_row = clos_ff;
      if (ctrl.warsh && clos_ff[ctrl.pivot_bit]) begin
         upd_row = clos_ff | pivot_row;
      end
      orig_in = load_en ? load_row : orig_ff;
      clos_in = clos_ff;
      if (load_en) begin
         clos_in = load_row;
      end else if (ctrl.shift) begin
         clos_in = nbr_row;
      end
   end

   always_ff @(posedge clock) begin
      orig_ff <= orig_in;
      clos_ff <= clos_in;
   end

   assign orig_row = orig_ff;
   assign clos_row = clos_ff;

endmodule

`default_nettype wire

>>> design/relation_property_closure.sv
// relation property check and closure generation, top level
// flow: n row beats to load, then a property check and warshall step per
// row, then 3n result beats (reflexive, symmetric, transitive closures),
// which wait on output stalls; rows of the next matrix stall until the last
// result beat has been issued, n = set_size clamped to 1 .. 16
// reset: synchronous active high, set_size back to 16 and the load count to 0
`default_nettype none

module relation_property_closure
   import rpc_pkg::*;
#(
   parameter int MAX_ELEMENTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [4:0]        csr_write_data,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [15:0]       req_row_bits,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_closure_kind,
   output logic [3:0]             rsp_row_index,
   output logic [15:0]            rsp_closure_row,
   output logic                   rsp_flag_reflexive,
   output logic                   rsp_flag_irreflexive,
   output logic                   rsp_flag_symmetric,
   output logic                   rsp_flag_antisymmetric,
   output logic                   rsp_flag_transitive,
   output logic                   rsp_last
);

   // rows in use never exceed the row width
   localparam int DEPTH = (MAX_ELEMENTS < ROW_W) ? MAX_ELEMENTS : ROW_W;
   localparam int IDXW  = $clog2(DEPTH);

   state_type        state_ff, state_in;
   logic [4:0]       size_ff, size_in;
   logic [3:0]       ld_ff, ld_in;       // next row to load
   logic [3:0]       cnt_ff, cnt_in;     // row / pivot counter
   logic [1:0]       kind_ff, kind_in;
   flags_type        flags_ff, flags_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [3:0]       out_idx_ff, out_idx_in;
   logic [15:0]      out_row_ff, out_row_in;
   flags_type        out_flags_ff, out_flags_in;
   logic             out_last_ff, out_last_in;

   logic [4:0]       n_eff;
   logic [3:0]       n_m1;
   logic [15:0]      mask;
   logic             req_beat;
   logic             fire;
   logic             cnt_end;
   cell_ctrl_type    ctrl;

   logic [15:0]      orig_rows [DEPTH];
   logic [15:0]      clos_rows [DEPTH];
   logic [15:0]      upd_rows  [DEPTH];
   logic [DEPTH-1:0] load_en;

   logic [15:0]      row_sel;            // original row at the counter
   logic [15:0]      col_sel;            // original column at the counter
   logic [15:0]      onehot;
   logic [15:0]      reach;              // or of rows reached in one step

   // element count clamped to 1 .. DEPTH
   always_comb begin
      n_eff = size_ff;
      if (size_ff == 5'd0) begin
         n_eff = 5'd1;
      end else if (size_ff > 5'(DEPTH)) begin
         n_eff = 5'(DEPTH);
      end
   end

   assign n_m1      = 4'(n_eff - 5'd1);
   assign mask      = row_mask(n_eff);
   assign req_stall = (state_ff != ST_LOAD);
   assign req_beat  = req_valid && !req_stall;
   assign cnt_end   = (cnt_ff == n_m1);
   assign fire      = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // closure rows rotate one cell per step while working, and per transitive beat
   always_comb begin
      ctrl.warsh     = (state_ff == ST_WORK);
      ctrl.shift     = (state_ff == ST_WORK) || (fire && kind_ff == KIND_TRANS);
      ctrl.pivot_bit = cnt_ff;
   end

   // the cell chain, ring length follows the element count
   // the pivot is the registered row in cell 0, an or with itself changes nothing
   for (genvar c = 0; c < DEPTH; c++) begin : g_cell
      logic [15:0] nbr;
      assign load_en[c] = req_beat && (ld_ff == 4'(c));
      assign nbr = (4'(c) == n_m1) ? upd_rows[0] : upd_rows[(c + 1) % DEPTH];
      rpc_cell u_cell (
         .clock     (clock),
         .load_en   (load_en[c]),
         .load_row  (req_row_bits & mask),
         .ctrl      (ctrl),
         .pivot_row (clos_rows[0]),
         .nbr_row   (nbr),
         .orig_row  (orig_rows[c]),
         .clos_row  (clos_rows[c]),
         .upd_row   (upd_rows[c])
      );
   end

   assign row_sel = orig_rows[cnt_ff[IDXW-1:0]];
   assign onehot  = 16'(1) << cnt_ff;

   // column and one-step reach gathered across the cells
   always_comb begin
      col_sel = '0;
      reach   = '0;
      for (int c = 0; c < DEPTH; c++) begin
         col_sel[c] = orig_rows[c][cnt_ff];
         if (row_sel[c]) begin
            reach = reach | orig_rows[c];
         end
      end
      col_sel = col_sel & mask;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      ld_in        = ld_ff;
      cnt_in       = cnt_ff;
      kind_in      = kind_ff;
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff;
      out_kind_in  = out_kind_ff;
      out_idx_in   = out_idx_ff;
      out_row_in   = out_row_ff;
      out_flags_in = out_flags_ff;
      out_last_in  = out_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_beat) begin
               if (ld_ff == n_m1) begin
                  ld_in    = '0;
                  cnt_in   = '0;
                  flags_in = '1;
                  state_in = ST_WORK;
               end else begin
                  ld_in = ld_ff + 4'd1;
               end
            end
         end
         ST_WORK: begin
            // property checks on row cnt, warshall pivot cnt in the cells
            if (row_sel[cnt_ff]) begin
               flags_in.irrefl = 1'b0;
            end else begin
               flags_in.refl = 1'b0;
            end
            if ((row_sel ^ col_sel) != '0) begin
               flags_in.sym = 1'b0;
            end
            if ((row_sel & col_sel & ~onehot) != '0) begin
               flags_in.anti = 1'b0;
            end
            if ((reach & ~row_sel) != '0) begin
               flags_in.trans = 1'b0;
            end
            if (cnt_end) begin
               cnt_in   = '0;
               kind_in  = KIND_REFL;
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_EMIT: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               out_kind_in  = kind_ff;
               out_idx_in   = cnt_ff;
               out_flags_in = flags_ff;
               out_last_in  = (kind_ff == KIND_TRANS) && cnt_end;
               case (kind_ff)
                  KIND_REFL: out_row_in = (row_sel | onehot) & mask;
                  KIND_SYM:  out_row_in = (row_sel | col_sel) & mask;
                  default:   out_row_in = upd_rows[0] & mask;
               endcase
               if (cnt_end) begin
                  cnt_in = '0;
                  if (kind_ff == KIND_TRANS) begin
                     state_in = ST_LOAD;
                  end else begin
                     kind_in = kind_ff + 2'd1;
                  end
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      // a set_size write drops any partly loaded matrix
      if (csr_write_enable) begin
         size_in = csr_write_data;
         ld_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         size_ff      <= 5'd16;
         ld_ff        <= '0;
         cnt_ff       <= '0;
         kind_ff      <= KIND_REFL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         ld_ff        <= ld_in;
         cnt_ff       <= cnt_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, held while the beat is stalled
   always_ff @(posedge clock) begin
      flags_ff     <= flags_in;
      out_kind_ff  <= out_kind_in;
      out_idx_ff   <= out_idx_in;
      out_row_ff   <= out_row_in;
      out_flags_ff <= out_flags_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_closure_kind       = out_kind_ff;
   assign rsp_row_index          = out_idx_ff;
   assign rsp_closure_row        = out_row_ff;
   assign rsp_flag_reflexive     = out_flags_ff.refl;
   assign rsp_flag_irreflexive   = out_flags_ff.irrefl;
   assign rsp_flag_symmetric     = out_flags_ff.sym;
   assign rsp_flag_antisymmetric = out_flags_ff.anti;
   assign rsp_flag_transitive    = out_flags_ff.trans;
   assign rsp_last               = out_last_ff;

`include "relation_property_closure_assert.svh"

   // only the transitive closure may close a burst
   `RPC_ASSERT_NOW(a_last_kind, clock, reset, rsp_valid_ff && out_last_ff, out_kind_ff == KIND_TRANS, "last beat not transitive")
   // the work phase hands over only to emission
   `RPC_ASSERT_NEXT(a_work_next, clock, reset, state_ff == ST_WORK, state_ff == ST_WORK || state_ff == ST_EMIT, "work phase left wrongly")
   // result row stays within the rows in use
   `RPC_ASSERT_NOW(a_row_range, clock, reset, rsp_valid_ff && !csr_write_enable, out_idx_ff <= n_m1, "row index beyond set size")

endmodule

`default_nettype wire

>>> tb/sv/relation_closure_checker.sv
// checker: predicts closure bursts from loaded rows and compares result beats
`timescale 1ns / 1ps
`default_nettype none

module relation_closure_checker
   import rpc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_write_data,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [15:0] req_row_bits,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_closure_kind,
   input  wire logic [3:0]  rsp_row_index,
   input  wire logic [15:0] rsp_closure_row,
   input  wire logic        rsp_flag_reflexive,
   input  wire logic        rsp_flag_irreflexive,
   input  wire logic        rsp_flag_symmetric,
   input  wire logic        rsp_flag_antisymmetric,
   input  wire logic        rsp_flag_transitive,
   input  wire logic        rsp_last,
   output int               error_count,
   output int               pending_rows,
   output int               matrices_seen,
   output int               rows_seen
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  index;
      logic [15:0] bits;
      flags_type   flags;
      logic        last;
   } closure_beat_type;

   closure_beat_type closure_rows_q[$];
   logic [4:0]    size_reg;
   logic [15:0]   loaded_rows [16];
   int            rows_loaded;

   assign pending_rows = closure_rows_q.size();

   function automatic int active_size(input logic [4:0] s);
      if (s < 1) return 1;
      if (s > 16) return 16;
      return s;
   endfunction

   task automatic predict_closures();
      int          n;
      logic [15:0] msk, row;
      logic [15:0] warsh [16];
      flags_type   f;
      closure_beat_type b;
      n = active_size(size_reg);
      msk = 16'((17'd1 << n) - 17'd1);
      f = '{refl: 1'b1, irrefl: 1'b1, sym: 1'b1, anti: 1'b1, trans: 1'b1};
      for (int i = 0; i < n; i++) begin
         if (loaded_rows[i][i]) f.irrefl = 1'b0; else f.refl = 1'b0;
         for (int j = 0; j < i; j++) begin
            if (loaded_rows[i][j] != loaded_rows[j][i]) f.sym = 1'b0;
            if (loaded_rows[i][j] && loaded_rows[j][i]) f.anti = 1'b0;
         end
         for (int j = 0; j < n; j++)
            if (loaded_rows[i][j] && (loaded_rows[j] & ~loaded_rows[i]) != 0)
               f.trans = 1'b0;
      end
      for (int i = 0; i < n; i++) begin
         b = '{kind: KIND_REFL, index: 4'(i), flags: f, last: 1'b0,
               bits: (loaded_rows[i] | (16'd1 << i)) & msk};
         closure_rows_q.insert(closure_rows_q.size(), b);
      end
      for (int i = 0; i < n; i++) begin
         row = loaded_rows[i];
         for (int j = 0; j < n; j++) if (loaded_rows[j][i]) row[j] = 1'b1;
         b = '{kind: KIND_SYM, index: 4'(i), bits: row & msk, flags: f, last: 1'b0};
         closure_rows_q.insert(closure_rows_q.size(), b);
      end
      for (int i = 0; i < 16; i++) warsh[i] = loaded_rows[i];
      for (int k = 0; k < n; k++)
         for (int i = 0; i < n; i++)
            if (warsh[i][k]) warsh[i] = warsh[i] | warsh[k];
      for (int i = 0; i < n; i++) begin
         b = '{kind: KIND_TRANS, index: 4'(i), bits: warsh[i] & msk, flags: f,
               last: (i == n - 1)};
         closure_rows_q.insert(closure_rows_q.size(), b);
      end
      matrices_seen <= matrices_seen + 1;
   endtask

   always @(posedge clock) begin
      closure_beat_type got, exp;
      if (reset) begin
         size_reg <= 5'd16;
         rows_loaded = 0;
         closure_rows_q.delete();
         error_count <= 0;
         matrices_seen <= 0;
         rows_seen <= 0;
      end else begin
         if (csr_write_enable) begin
            size_reg <= csr_write_data;
            rows_loaded = 0;
         end else if (req_valid && !req_stall) begin
            if (rows_loaded >= active_size(size_reg)) rows_loaded = 0;
            loaded_rows[rows_loaded] = req_row_bits
               & 16'((17'd1 << active_size(size_reg)) - 17'd1);
            rows_loaded++;
            if (rows_loaded == active_size(size_reg)) begin
               rows_loaded = 0;
               predict_closures();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            rows_seen <= rows_seen + 1;
            got = '{kind: rsp_closure_kind, index: rsp_row_index, bits: rsp_closure_row,
                    flags: '{refl: rsp_flag_reflexive, irrefl: rsp_flag_irreflexive,
                             sym: rsp_flag_symmetric, anti: rsp_flag_antisymmetric,
                             trans: rsp_flag_transitive},
                    last: rsp_last};
            if (closure_rows_q.size() == 0) begin
               $error("result beat with nothing expected");
               error_count <= error_count + 1;
            end else begin
               exp = closure_rows_q.pop_front();
               if (got != exp) begin
                  error_count <= error_count + 1;
                  if (got.kind != exp.kind)
                     $error("closure_kind exp %0d got %0d", exp.kind, got.kind);
                  if (got.index != exp.index)
                     $error("row_index exp %0d got %0d", exp.index, got.index);
                  if (got.bits != exp.bits)
                     $error("closure_row exp %h got %h", exp.bits, got.bits);
                  if (got.flags.refl != exp.flags.refl)
                     $error("flag_reflexive exp %b got %b", exp.flags.refl, got.flags.refl);
                  if (got.flags.irrefl != exp.flags.irrefl)
                     $error("flag_irreflexive exp %b got %b",
                            exp.flags.irrefl, got.flags.irrefl);
                  if (got.flags.sym != exp.flags.sym)
                     $error("flag_symmetric exp %b got %b", exp.flags.sym, got.flags.sym);
                  if (got.flags.anti != exp.flags.anti)
                     $error("flag_antisymmetric exp %b got %b",
                            exp.flags.anti, got.flags.anti);
                  if (got.flags.trans != exp.flags.trans)
                     $error("flag_transitive exp %b got %b", exp.flags.trans, got.flags.trans);
                  if (got.last != exp.last)
                     $error("last exp %b got %b", exp.last, got.last);
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// top of the closure block testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module testbench;
   import rpc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [4:0]  csr_write_data = 5'd0;
   logic        req_valid = 1'b0;
   logic [15:0] req_row_bits = 16'd0;
   logic        rsp_stall = 1'b0;
   logic        req_stall, rsp_valid, rsp_last;
   logic [1:0]  rsp_closure_kind;
   logic [3:0]  rsp_row_index;
   logic [15:0] rsp_closure_row;
   logic        rsp_flag_reflexive, rsp_flag_irreflexive, rsp_flag_symmetric;
   logic        rsp_flag_antisymmetric, rsp_flag_transitive;
   int          error_count, pending_rows, matrices_seen, rows_seen;

   // idling knobs: percent chance of a gap, zero during the quiet stretch
   int          sender_idle_pct = 33;
   int          receiver_idle_pct = 33;
   bit          hold_receiver = 1'b0;
   int          beats_sent = 0;

   always #1 clock = ~clock;

   relation_property_closure DUT (.*);

   relation_closure_checker checker_inst (.*);

   // receiver: random stall, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_receiver || ($urandom_range(99) < receiver_idle_pct);
   end

   // write set_size while the block is idle
   task automatic write_size(input logic [4:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // offer one row beat, hold it until accepted; valid stays up for the next row
   task automatic send_row(input logic [15:0] bits);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_row_bits <= bits;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // let every predicted row drain, then a margin for in-flight work
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rows != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // random rows shaped toward interesting relations
   function automatic logic [15:0] shaped_row(input int i, input int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'(1 << i);                          // identity-ish
         2: return 16'($urandom) | 16'(1 << i);          // reflexive
         3: return 16'($urandom) & ~16'(1 << i);         // irreflexive
         4: return 16'(($urandom & 3) ? 0 : $urandom);   // sparse
         default: return 16'hFFFF;
      endcase
   endfunction

   task automatic random_matrices(input int size, input int count);
      int style;
      for (int m = 0; m < count; m++) begin
         style = $urandom_range(5);
         for (int i = 0; i < size; i++) send_row(shaped_row(i, style));
      end
   endtask

   initial begin
      int sizes [6] = '{1, 2, 3, 5, 8, 16};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset size 16, all ones then chain relation
      for (int i = 0; i < 16; i++) send_row(16'hFFFF);
      for (int i = 0; i < 16; i++) send_row(i < 15 ? 16'(1 << (i + 1)) : 16'h0000);
      drain();

      // size 0 acts as 1; then 31 clamps to 16
      write_size(5'd0);
      send_row(16'h0001);
      send_row(16'hFFFE);
      drain();
      // partial load dropped by a size write
      write_size(5'd3);
      send_row(16'h0005);
      write_size(5'd2);
      send_row(16'h0002);
      send_row(16'h0001);
      drain();
      write_size(5'd31);
      random_matrices(16, 1);
      drain();

      // random phases across sizes, no idling in one
      for (int p = 0; p < 12; p++) begin
         write_size(5'(sizes[p % 6]));
         if (p == 6) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end else begin
            sender_idle_pct = 33;
            receiver_idle_pct = 33;
         end
         random_matrices(sizes[p % 6], sizes[p % 6] > 8 ? 2 : 24 / sizes[p % 6]);
         drain();
      end

      // back-pressure: receiver holds off while rows keep coming
      write_size(5'd4);
      fork
         begin
            hold_receiver = 1'b1;
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
         random_matrices(4, 8);
      join
      drain();

      $display("covered %0d row beats, %0d matrices, %0d closure rows checked",
               beats_sent, matrices_seen, rows_seen);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
